[rtl/ntcmf_pkg.sv]
// shared constants, thermistor table and result types for the ntc temperature filter
package ntcmf_pkg;

  // input sample and temperature value widths
  localparam int ADC_W = 12;
  localparam int VAL_W = 10;
  localparam int STATUS_W = 2;
  localparam int FILL_OUT_W = 4;

  // thermistor table geometry
  localparam int TABLE_ENTRIES = 100;
  localparam int ROM_COUNT = 100;
  localparam int ROM_N = (TABLE_ENTRIES > ROM_COUNT) ? ROM_COUNT :
                         ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int IDX_W = $clog2(ROM_COUNT + 1);
  localparam int ROM_AW = $clog2(ROM_COUNT);
  localparam int NUM_W = ADC_W + 4;
  localparam logic [VAL_W-1:0] HOT_VALUE = VAL_W'((ROM_N - 1) * 10);

  // filter window geometry
  localparam int WINDOW_DEPTH = 10;
  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = VAL_W + $clog2(WINDOW_DEPTH);
  localparam int FILL_MIN_AVG = 3;

  // range status codes
  localparam logic [STATUS_W-1:0] ST_IN_TABLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COLD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HOT = 2'd2;

  // divider readings, one per degree from 0 C, strictly descending
  localparam logic [ADC_W-1:0] NTC_ROM [ROM_COUNT] = '{
    12'd3123, 12'd3089, 12'd3051, 12'd3013, 12'd2973, 12'd2933, 12'd2893, 12'd2852,
    12'd2810, 12'd2767, 12'd2720, 12'd2681, 12'd2637, 12'd2593, 12'd2548, 12'd2503,
    12'd2458, 12'd2412, 12'd2367, 12'd2321, 12'd2275, 12'd2230, 12'd2184, 12'd2138,
    12'd2093, 12'd2048, 12'd2002, 12'd1958, 12'd1913, 12'd1869, 12'd1825, 12'd1782,
    12'd1739, 12'd1697, 12'd1655, 12'd1614, 12'd1573, 12'd1533, 12'd1494, 12'd1455,
    12'd1417, 12'd1380, 12'd1343, 12'd1307, 12'd1272, 12'd1237, 12'd1203, 12'd1170,
    12'd1138, 12'd1106, 12'd1081, 12'd1045, 12'd1016, 12'd987,  12'd959,  12'd932,
    12'd905,  12'd879,  12'd854,  12'd829,  12'd806,  12'd782,  12'd760,  12'd738,
    12'd716,  12'd696,  12'd675,  12'd656,  12'd637,  12'd618,  12'd600,  12'd583,
    12'd566,  12'd550,  12'd534,  12'd518,  12'd503,  12'd489,  12'd475,  12'd461,
    12'd448,  12'd435,  12'd422,  12'd410,  12'd398,  12'd387,  12'd376,  12'd365,
    12'd355,  12'd345,  12'd335,  12'd326,  12'd316,  12'd308,  12'd299,  12'd290,
    12'd283,  12'd274,  12'd267,  12'd259
  };

  // converter result
  typedef struct packed {
    logic [VAL_W-1:0]    inst;
    logic [STATUS_W-1:0] status;
  } conv_res_t;

  // window filter result
  typedef struct packed {
    logic [VAL_W-1:0]  filt;
    logic [FILL_W-1:0] fill;
  } win_res_t;

endpackage

[rtl/ntcmf_in_if.sv]
// sample input channel
interface ntcmf_in_if;
  logic                          valid;
  logic                          ready;
  logic [ntcmf_pkg::ADC_W-1:0]   adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

[rtl/ntcmf_out_if.sv]
// temperature result channel
interface ntcmf_out_if;
  logic                              valid;
  logic                              ready;
  logic [ntcmf_pkg::VAL_W-1:0]       temp_tenths;
  logic [ntcmf_pkg::VAL_W-1:0]       instant_tenths;
  logic [ntcmf_pkg::STATUS_W-1:0]    range_status;
  logic [ntcmf_pkg::FILL_OUT_W-1:0]  window_fill;

  modport source (output valid, output temp_tenths, output instant_tenths,
                  output range_status, output window_fill, input ready);
  modport sink   (input valid, input temp_tenths, input instant_tenths,
                  input range_status, input window_fill, output ready);
endinterface

[rtl/ntcmf_conv.sv]
// adc to tenths of a degree: table binary search and interpolation divider
module ntcmf_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ntcmf_pkg::ADC_W-1:0]   key,
  output logic                          done,
  output ntcmf_pkg::conv_res_t          res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_INTP = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]                        state_r;
  logic [ntcmf_pkg::ADC_W-1:0]       key_r;
  logic [ntcmf_pkg::IDX_W-1:0]       lo_r, hi_r;
  logic [ntcmf_pkg::NUM_W-1:0]       rem_r;
  logic [ntcmf_pkg::ADC_W-1:0]       span_r;
  logic [ntcmf_pkg::VAL_W-1:0]       base_r;
  logic [1:0]                        qbit_r;
  logic [3:0]                        quo_r;
  logic                              done_r;
  ntcmf_pkg::conv_res_t              res_r;

  logic [ntcmf_pkg::IDX_W:0]         mid_sum;
  logic [ntcmf_pkg::IDX_W-1:0]       mid;
  logic [ntcmf_pkg::IDX_W-1:0]       lo_m1;
  logic [ntcmf_pkg::ADC_W-1:0]       upper, lower, mid_entry;
  logic [ntcmf_pkg::NUM_W-1:0]       trial;
  logic                              take;
  logic [3:0]                        quo_nxt;

  // search midpoint and table reads
  always_comb begin
    mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
    mid       = mid_sum[ntcmf_pkg::IDX_W:1];
    lo_m1     = lo_r - 1'b1;
    mid_entry = ntcmf_pkg::NTC_ROM[mid[ntcmf_pkg::ROM_AW-1:0]];
    upper     = ntcmf_pkg::NTC_ROM[lo_m1[ntcmf_pkg::ROM_AW-1:0]];
    lower     = ntcmf_pkg::NTC_ROM[lo_r[ntcmf_pkg::ROM_AW-1:0]];
  end

  // one quotient bit per cycle, quotient never exceeds ten
  always_comb begin
    trial   = ntcmf_pkg::NUM_W'({4'd0, span_r} << qbit_r);
    take    = (rem_r >= trial);
    quo_nxt = quo_r;
    quo_nxt[qbit_r] = take;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            key_r   <= key;
            lo_r    <= '0;
            hi_r    <= ntcmf_pkg::IDX_W'(ntcmf_pkg::ROM_N);
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_r < hi_r) begin
            if (key_r >= mid_entry) begin
              hi_r <= mid;
            end else begin
              lo_r <= mid + 1'b1;
            end
          end else begin
            state_r <= S_INTP;
          end
        end
        S_INTP: begin
          if (lo_r == '0) begin
            res_r.inst   <= '0;
            res_r.status <= ntcmf_pkg::ST_COLD;
            done_r       <= 1'b1;
            state_r      <= S_IDLE;
          end else if (lo_r >= ntcmf_pkg::IDX_W'(ntcmf_pkg::ROM_N)) begin
            res_r.inst   <= ntcmf_pkg::HOT_VALUE;
            res_r.status <= ntcmf_pkg::ST_HOT;
            done_r       <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            span_r <= upper - lower;
            rem_r  <= ntcmf_pkg::NUM_W'(upper - key_r) * ntcmf_pkg::NUM_W'(10);
            base_r <= ntcmf_pkg::VAL_W'(lo_m1) * ntcmf_pkg::VAL_W'(10);
            qbit_r <= 2'd3;
            quo_r  <= '0;
            res_r.status <= ntcmf_pkg::ST_IN_TABLE;
            if (upper == lower) begin
              res_r.inst <= ntcmf_pkg::VAL_W'(lo_m1) * ntcmf_pkg::VAL_W'(10);
              done_r     <= 1'b1;
              state_r    <= S_IDLE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (take) begin
            rem_r <= rem_r - trial;
          end
          quo_r <= quo_nxt;
          if (qbit_r == 2'd0) begin
            res_r.inst <= base_r + ntcmf_pkg::VAL_W'(quo_nxt);
            done_r     <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            qbit_r <= qbit_r - 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

[rtl/ntcmf_win.sv]
// sliding window memory with sum, max, min scan and averaging divider
module ntcmf_win (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ntcmf_pkg::VAL_W-1:0]  val,
  input  logic                         ack,
  output logic                         done,
  output ntcmf_pkg::win_res_t          res
);

  localparam int BIT_W = $clog2(ntcmf_pkg::SUM_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [ntcmf_pkg::VAL_W-1:0]   win_mem [ntcmf_pkg::WINDOW_DEPTH];
  logic [ntcmf_pkg::VAL_W-1:0]   rd_data_r;

  logic [1:0]                    state_r;
  logic [ntcmf_pkg::WIN_AW-1:0]  wp_r;
  logic [ntcmf_pkg::FILL_W-1:0]  fill_r;
  logic [ntcmf_pkg::VAL_W-1:0]   first_r;
  logic [ntcmf_pkg::FILL_W-1:0]  iss_r;
  logic                          rd_vld_r;
  logic [ntcmf_pkg::SUM_W-1:0]   sum_r;
  logic [ntcmf_pkg::VAL_W-1:0]   max_r, min_r;
  logic [ntcmf_pkg::FILL_W-1:0]  dvs_r;
  logic [ntcmf_pkg::FILL_W-1:0]  rem_r;
  logic [ntcmf_pkg::SUM_W-1:0]   quo_r;
  logic [BIT_W-1:0]              bit_r;
  ntcmf_pkg::win_res_t           res_r;

  logic                          wr_en;
  logic                          rd_en;
  logic [ntcmf_pkg::FILL_W-1:0]  fill_nxt;
  logic [ntcmf_pkg::FILL_W:0]    trial;
  logic                          take;
  logic [ntcmf_pkg::FILL_W:0]    diff;
  logic [ntcmf_pkg::SUM_W-1:0]   quo_nxt;

  // control decode
  always_comb begin
    wr_en    = (state_r == S_IDLE) && start;
    rd_en    = (state_r == S_SCAN) && (iss_r != fill_r);
    fill_nxt = (fill_r < ntcmf_pkg::FILL_W'(ntcmf_pkg::WINDOW_DEPTH)) ?
               fill_r + 1'b1 : fill_r;
  end

  // window memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wp_r] <= val;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[iss_r[ntcmf_pkg::WIN_AW-1:0]];
    end
  end

  // restoring divider step
  always_comb begin
    trial   = {rem_r, quo_r[ntcmf_pkg::SUM_W-1]};
    take    = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    quo_nxt = {quo_r[ntcmf_pkg::SUM_W-2:0], take};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      fill_r   <= '0;
      first_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            wp_r <= (wp_r == ntcmf_pkg::WIN_AW'(ntcmf_pkg::WINDOW_DEPTH - 1)) ?
                    '0 : wp_r + 1'b1;
            fill_r <= fill_nxt;
            if (fill_r == '0) begin
              first_r <= val;
            end
            res_r.fill <= fill_nxt;
            if (fill_nxt < ntcmf_pkg::FILL_W'(ntcmf_pkg::FILL_MIN_AVG)) begin
              res_r.filt <= (fill_r == '0) ? val : first_r;
              state_r    <= S_DONE;
            end else begin
              iss_r   <= '0;
              sum_r   <= '0;
              max_r   <= '0;
              min_r   <= '1;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld_r <= rd_en;
          if (rd_en) begin
            iss_r <= iss_r + 1'b1;
          end
          if (rd_vld_r) begin
            sum_r <= sum_r + ntcmf_pkg::SUM_W'(rd_data_r);
            if (rd_data_r > max_r) max_r <= rd_data_r;
            if (rd_data_r < min_r) min_r <= rd_data_r;
          end
          if (!rd_en && !rd_vld_r) begin
            quo_r   <= sum_r - ntcmf_pkg::SUM_W'(max_r) - ntcmf_pkg::SUM_W'(min_r);
            rem_r   <= '0;
            dvs_r   <= fill_r - ntcmf_pkg::FILL_W'(2);
            bit_r   <= BIT_W'(ntcmf_pkg::SUM_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= take ? diff[ntcmf_pkg::FILL_W-1:0] : trial[ntcmf_pkg::FILL_W-1:0];
          quo_r <= quo_nxt;
          if (bit_r == '0) begin
            res_r.filt <= quo_nxt[ntcmf_pkg::VAL_W-1:0];
            state_r    <= S_DONE;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        S_DONE: begin
          if (ack) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = (state_r == S_DONE);
  assign res  = res_r;

endmodule

[rtl/ntc_adc_to_temp_median_filter_top.sv]
// top level of the ntc temperature converter with median-average filter
//
//   channel  dir  payload                                              handshake
//   in_if    in   adc_sample[11:0]                                     valid/ready
//   out_if   out  temp_tenths[9:0] instant_tenths[9:0]                 valid/ready
//                 range_status[1:0] window_fill[3:0]
//
// one item at a time: up to 7 search steps and a closing compare, 1 interpolation
// set-up and 4 divide steps in the converter (clamped samples skip the divide),
// then 1 window write, a scan of the filled entries, 14 divide steps and a hand-off
// in the window unit (short windows skip the scan and divide) before the next input item.
// rst_n is synchronous, active low; window contents need no clearing.
// a finished result sits in the output register while the next item is taken;
// the window unit waits on its result only if that register is still full.
module ntc_adc_to_temp_median_filter_top (
  input  logic                clk,
  input  logic                rst_n,
  ntcmf_in_if.sink            in_if,
  ntcmf_out_if.source         out_if
);

  logic                        busy_r;
  logic                        out_valid_r;
  logic [ntcmf_pkg::VAL_W-1:0]       temp_r;
  logic [ntcmf_pkg::VAL_W-1:0]       inst_r;
  logic [ntcmf_pkg::STATUS_W-1:0]    status_r;
  logic [ntcmf_pkg::FILL_OUT_W-1:0]  fill_r;

  logic                        in_take;
  logic                        conv_done;
  ntcmf_pkg::conv_res_t        conv_res;
  logic                        win_done;
  logic                        win_ack;
  ntcmf_pkg::win_res_t         win_res;

  // handshake
  assign in_if.ready = !busy_r;
  assign in_take     = in_if.valid && !busy_r;
  assign win_ack     = win_done && (!out_valid_r || out_if.ready);

  // table conversion
  ntcmf_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .key   (in_if.adc_sample),
    .done  (conv_done),
    .res   (conv_res)
  );

  // window filter
  ntcmf_win u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .val   (conv_res.inst),
    .ack   (win_ack),
    .done  (win_done),
    .res   (win_res)
  );

  // busy flag and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        busy_r <= 1'b1;
      end else if (win_ack) begin
        busy_r <= 1'b0;
      end
      if (win_ack) begin
        out_valid_r <= 1'b1;
        temp_r      <= win_res.filt;
        inst_r      <= conv_res.inst;
        status_r    <= conv_res.status;
        fill_r      <= ntcmf_pkg::FILL_OUT_W'(win_res.fill);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.temp_tenths    = temp_r;
  assign out_if.instant_tenths = inst_r;
  assign out_if.range_status   = status_r;
  assign out_if.window_fill    = fill_r;

endmodule
